>>> hw/rtl/json_string_unescape_utf8_assert.svh
// assertion macros for the json string unescaper
// used by the top level only, needs no package
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jsu_pkg.sv
// types, character codes and helpers shared by the json string unescaper
// no dependencies
package jsu_pkg;

    // word on the input channel
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // word on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // most bytes that one input word can produce
    localparam int GROUP_MAX = 5;
    localparam int GROUP_CW  = $clog2(GROUP_MAX + 1);

    // bytes produced by one input word, handed from front to back
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic [GROUP_CW-1:0]       count;
        logic                      last;
    } t_group;

    // queue between the two halves
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // decoder state
    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2
    } t_mode;

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;

    // utf-8 encoding
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;
    localparam logic [15:0] CP_ONE_LIMIT   = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT   = 16'h0800;

    // digits held before the fourth one arrives
    localparam int          HELD_MAX  = 3;
    localparam logic [1:0]  HEX_FULL  = 2'd3;

    // hex digit decode: bit 4 says the byte is a digit
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                return {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

endpackage

>>> hw/rtl/jsu_front.sv
// front half: takes input words, runs the escape decoder, builds byte groups
// depends on jsu_pkg
module jsu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_in       i_in,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_q_status i_q_status,
    output logic               o_push,
    output jsu_pkg::t_group    o_group
);
    import jsu_pkg::*;

    t_mode      r_mode, n_mode;
    logic [1:0] r_hex_count, n_hex_count;
    logic [11:0] r_hex_value, n_hex_value;
    logic [7:0] r_held [HELD_MAX];
    logic [7:0] n_held [HELD_MAX];

    logic        fire;
    logic [7:0]  b;
    logic        last;
    logic [4:0]  hex;
    logic        digit_ok;
    logic [15:0] cp;
    logic [GROUP_CW-1:0] gb_count;
    t_group      grp;

    assign b        = i_in.in_byte;
    assign last     = i_in.in_last;
    assign hex      = hex_of(b);
    assign digit_ok = hex[4];
    assign cp       = {r_hex_value, hex[3:0]};
    assign gb_count = GROUP_CW'(r_hex_count) + GROUP_CW'(1);

    assign o_in_stall = i_q_status.full;
    assign fire       = i_in_valid && !i_q_status.full;

    // next decoder state
    always_comb begin
        n_mode = r_mode;
        if (fire) begin
            if (last) begin
                n_mode = MODE_PLAIN;
            end else begin
                unique case (r_mode)
                    MODE_ESC: begin
                        n_mode = (b == CH_U) ? MODE_HEX : MODE_PLAIN;
                    end
                    MODE_HEX: begin
                        if (!digit_ok) begin
                            n_mode = (b == CH_BACKSLASH) ? MODE_ESC : MODE_PLAIN;
                        end else if (r_hex_count == HEX_FULL) begin
                            n_mode = MODE_PLAIN;
                        end
                    end
                    default: begin
                        n_mode = (b == CH_BACKSLASH) ? MODE_ESC : MODE_PLAIN;
                    end
                endcase
            end
        end
    end

    // output bytes and hex datapath
    always_comb begin
        grp         = '0;
        grp.last    = last;
        n_hex_count = r_hex_count;
        n_hex_value = r_hex_value;
        for (int k = 0; k < HELD_MAX; k++) begin
            n_held[k] = r_held[k];
        end

        unique case (r_mode)
            MODE_ESC: begin
                grp.count = GROUP_CW'(1);
                unique case (b)
                    CH_N: grp.bytes[0] = CH_LF;
                    CH_T: grp.bytes[0] = CH_TAB;
                    CH_R: grp.bytes[0] = CH_CR;
                    CH_B: grp.bytes[0] = CH_BS;
                    CH_F: grp.bytes[0] = CH_FF;
                    CH_U: begin
                        // start collecting unless the string ends here
                        grp.bytes[0] = CH_U;
                        if (!last) begin
                            grp.count   = '0;
                            n_hex_count = '0;
                            n_hex_value = '0;
                        end
                    end
                    default: grp.bytes[0] = b;
                endcase
            end
            MODE_HEX: begin
                if (!digit_ok || (last && r_hex_count != HEX_FULL)) begin
                    // give back 'u' and the held digits, then maybe this byte
                    grp.bytes[0] = CH_U;
                    for (int k = 0; k < HELD_MAX; k++) begin
                        grp.bytes[k+1] = r_held[k];
                    end
                    for (int k = 1; k < GROUP_MAX; k++) begin
                        if (GROUP_CW'(k) == gb_count) begin
                            grp.bytes[k] = b;
                        end
                    end
                    if (digit_ok || b != CH_BACKSLASH || last) begin
                        grp.count = gb_count + GROUP_CW'(1);
                    end else begin
                        grp.count = gb_count;
                    end
                    n_hex_count = '0;
                    n_hex_value = '0;
                end else if (r_hex_count == HEX_FULL) begin
                    // fourth digit: encode the code point
                    if (cp < CP_ONE_LIMIT) begin
                        grp.bytes[0] = cp[7:0];
                        grp.count    = GROUP_CW'(1);
                    end else if (cp < CP_TWO_LIMIT) begin
                        grp.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
                        grp.bytes[1] = UTF8_CONT | (cp[7:0] & UTF8_CONT_MASK);
                        grp.count    = GROUP_CW'(2);
                    end else begin
                        grp.bytes[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
                        grp.bytes[1] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_CONT_MASK);
                        grp.bytes[2] = UTF8_CONT | (cp[7:0] & UTF8_CONT_MASK);
                        grp.count    = GROUP_CW'(3);
                    end
                    n_hex_count = '0;
                    n_hex_value = '0;
                end else begin
                    // hold the digit with its case
                    for (int k = 0; k < HELD_MAX; k++) begin
                        if (2'(k) == r_hex_count) begin
                            n_held[k] = b;
                        end
                    end
                    n_hex_count = r_hex_count + 2'd1;
                    n_hex_value = {r_hex_value[7:0], hex[3:0]};
                end
            end
            default: begin
                grp.bytes[0] = b;
                grp.count    = (b == CH_BACKSLASH && !last) ? '0 : GROUP_CW'(1);
            end
        endcase

        if (last) begin
            n_hex_count = '0;
            n_hex_value = '0;
        end
    end

    assign o_group = grp;
    assign o_push  = fire && (grp.count != '0);

    // decoder registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PLAIN;
            r_hex_count <= '0;
            r_hex_value <= '0;
        end else if (fire) begin
            r_mode      <= n_mode;
            r_hex_count <= n_hex_count;
            r_hex_value <= n_hex_value;
        end
    end

    // held digit bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < HELD_MAX; k++) begin
                r_held[k] <= n_held[k];
            end
        end
    end

endmodule

>>> hw/rtl/jsu_queue.sv
// short queue of byte groups between the front and back halves
// depends on jsu_pkg
module jsu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jsu_pkg::t_group    i_group,
    input  logic               i_pop,
    output jsu_pkg::t_q_status o_status,
    output jsu_pkg::t_group    o_head
);
    import jsu_pkg::*;

    t_group          r_entry [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_fill, n_fill;

    // pointer and fill updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + Q_CW'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_group;
        end
    end

    assign o_status.full  = (r_fill == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_head         = r_entry[r_rd_ptr];

endmodule

>>> hw/rtl/jsu_back.sv
// back half: walks each byte group and drives the output register
// depends on jsu_pkg
module jsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsu_pkg::t_q_status i_q_status,
    input  jsu_pkg::t_group    i_head,
    output logic               o_pop,
    output jsu_pkg::t_out      o_out,
    output logic               o_out_valid,
    input  logic               i_out_stall
);
    import jsu_pkg::*;

    logic [GROUP_CW-1:0] r_idx, n_idx;
    logic                r_valid;
    t_out                r_out;

    logic load;
    logic take;
    logic at_end;

    assign load   = !r_valid || !i_out_stall;
    assign take   = load && !i_q_status.empty;
    assign at_end = (r_idx == i_head.count - GROUP_CW'(1));
    assign o_pop  = take && at_end;

    // byte index within the head group
    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = at_end ? '0 : r_idx + GROUP_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= !i_q_status.empty;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_byte <= i_head.bytes[r_idx];
            r_out.out_last <= i_head.last && at_end;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_valid;

endmodule

>>> hw/rtl/json_string_unescape_utf8.sv
// json string unescaper: one escaped byte in per cycle while not stalled, unescaped utf-8 out.
// path: a byte taken is decoded into a byte group, queued, then registered at the output.
// throughput: one input word per cycle while each makes one byte and output is not
// stalled; a word making n bytes (up to five) keeps the single output register for them.
// reset: synchronous active low; clears decoder state, group queue and output valid.
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_in  i_in,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output jsu_pkg::t_out o_out,
    output logic          o_out_valid,
    input  logic          i_out_stall
);
    import jsu_pkg::*;

    t_q_status q_status;
    t_group    push_group;
    t_group    head_group;
    logic      q_push;
    logic      q_pop;
    logic      group_ok;

    // decoder
    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_group    (push_group)
    );

    // group queue
    jsu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_group  (push_group),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_head   (head_group)
    );

    // serialiser
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (head_group),
        .o_pop       (q_pop),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    // a pushed group holds one to five bytes
    assign group_ok = (push_group.count != '0) &&
                      (push_group.count <= GROUP_CW'(GROUP_MAX));

    // queue and group checks
    `JSU_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, q_push, !q_status.full, "push into full queue")
    `JSU_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_status.empty, "pop from empty queue")
    `JSU_ASSERT_NOW(a_group_size, i_clk, i_rst_n, q_push, group_ok, "bad group size")
    `JSU_ASSERT_NEXT(a_valid_after_pop, i_clk, i_rst_n, q_pop, o_out_valid, "pop left no output")

endmodule
